// ----- hw/rtl/tmma_pkg.sv -----
// Shared types and constants for the tiled matrix multiply-accumulate block.
// No dependencies; imported by tmma_ctrl, tmma_dp and the top level.
package tmma_pkg;

    // Matrix geometry
    localparam int MAX_DIM = 64;
    localparam int IDX_W   = 6;                // row / column index width
    localparam int ADDR_W  = 2 * IDX_W;        // {row, col} element address
    localparam int DIM_W   = 7;                // dim_in_use register width
    localparam int DATA_W  = 32;
    localparam int CELLS   = MAX_DIM * MAX_DIM;

    // Stream payload widths
    localparam int IN_DATA_W  = 48;            // row, col, value padded to bytes
    localparam int IN_USER_W  = 3;             // action
    localparam int OUT_DATA_W = 48;            // out_row, out_col, out_value padded

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    // Action codes
    localparam logic [IN_USER_W-1:0] ACT_WR_A    = 3'd0;
    localparam logic [IN_USER_W-1:0] ACT_WR_B    = 3'd1;
    localparam logic [IN_USER_W-1:0] ACT_WR_C    = 3'd2;
    localparam logic [IN_USER_W-1:0] ACT_COMPUTE = 3'd3;
    localparam logic [IN_USER_W-1:0] ACT_RD_C    = 3'd4;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Controller -> datapath commands
    typedef struct packed {
        logic              wr_a;       // item write of A
        logic              wr_b;       // item write of B
        logic              wr_c;       // item write of C
        logic              rd_c;       // item read of C
        logic              mac_issue;  // one multiply-accumulate step issued
        logic              mac_first;  // first k of an element
        logic              mac_last;   // last k of an element
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic [ADDR_W-1:0] c_raddr;
        logic              push_rd;    // queue the C read response
        logic              push_done;  // queue the compute-finished result
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic [OQ_CNT_W-1:0] oq_count;
    } t_dp_status;

    // One result entry
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_out_item;

endpackage

// ----- hw/rtl/tiled_matrix_multiply_accumulate.sv -----
// Top level of the integer matrix multiply-accumulate block (C = C + A*B).
// Depends on tmma_pkg, tmma_ctrl and tmma_dp.
//
//  channel   | direction | transfers
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | one item: write A/B/C, compute, or read C
//  m_axis    | out       | read data of a C element, or compute finished
//  cfg       | in        | dim_in_use write, taken on any edge with i_cfg_we
//
// Writes are stored as they are accepted. A C read is taken back to back; its
// data is queued in the cycle after acceptance. A compute walks n*n*n
// multiply-accumulate steps, one per cycle through the single multiplier and the
// A/B read ports, then drains the pipeline; the next item is taken only after the
// compute-finished result is queued (n = dim_in_use limited to 64). Results wait
// in a four-entry queue; input stalls once queued results plus a read still in
// flight reach four. Reset is synchronous and needs no clearing pass; matrix
// contents are undefined until written.
module tiled_matrix_multiply_accumulate (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tmma_pkg::DIM_W-1:0]        i_cfg_wdata,      // dim_in_use
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [tmma_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,   // row, col, value
    input  logic [tmma_pkg::IN_USER_W-1:0]    i_s_axis_tuser,   // action
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tmma_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,   // out_row, out_col, out_value
    output logic                              o_m_axis_tuser    // kind
);
    import tmma_pkg::*;

    t_dp_cmd           cmd;
    t_dp_status        status;
    t_out_item         out_item;
    logic [IDX_W-1:0]  in_row, in_col;
    logic [DATA_W-1:0] in_value;

    // Unpack input transaction
    assign in_row   = i_s_axis_tdata[IDX_W-1:0];
    assign in_col   = i_s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = i_s_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

    tmma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_valid   (i_s_axis_tvalid),
        .i_action    (i_s_axis_tuser),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_status    (status),
        .o_ready     (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    tmma_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_value     (in_value),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_item  (out_item),
        .o_status    (status)
    );

    // Pack output transaction
    assign o_m_axis_tdata = {{(OUT_DATA_W - 2*IDX_W - DATA_W){1'b0}},
                             out_item.value, out_item.col, out_item.row};
    assign o_m_axis_tuser = out_item.kind;

endmodule

// ----- hw/rtl/tmma_ctrl.sv -----
// Controller for the matrix multiply-accumulate block: item decode, dimension
// register and the compute loop sequencer. Depends on tmma_pkg.
module tmma_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tmma_pkg::DIM_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_valid,
    input  logic [tmma_pkg::IN_USER_W-1:0] i_action,
    input  logic [tmma_pkg::IDX_W-1:0]    i_row,
    input  logic [tmma_pkg::IDX_W-1:0]    i_col,
    input  tmma_pkg::t_dp_status          i_status,
    output logic                          o_ready,
    output tmma_pkg::t_dp_cmd             o_cmd
);
    import tmma_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [DIM_W-1:0] r_dim;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_nm1, n_nm1;
    logic             r_drain, n_drain;
    logic             r_rd_pend, n_rd_pend;
    logic [DIM_W-1:0] dim_eff;
    logic             accept;

    // Effective dimension, limited to the storage size
    assign dim_eff = (r_dim > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_dim;

    // Take an item only when idle and the result queue can hold everything in flight
    assign o_ready = (r_state == ST_IDLE) &&
                     (OQ_CNT_W'(i_status.oq_count + OQ_CNT_W'(r_rd_pend)) <
                      OQ_CNT_W'(OQ_DEPTH));
    assign accept  = i_s_valid && o_ready;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_nm1     = r_nm1;
        n_drain   = r_drain;
        n_rd_pend = 1'b0;
        o_cmd           = '0;
        o_cmd.a_addr    = {r_i, r_k};
        o_cmd.b_addr    = {r_k, r_j};
        o_cmd.c_raddr   = (r_state == ST_CALC) ? {r_i, r_j} : {i_row, i_col};
        o_cmd.push_rd   = r_rd_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_WR_A: o_cmd.wr_a = 1'b1;
                        ACT_WR_B: o_cmd.wr_b = 1'b1;
                        ACT_WR_C: o_cmd.wr_c = 1'b1;
                        ACT_RD_C: begin
                            o_cmd.rd_c = 1'b1;
                            n_rd_pend  = 1'b1;
                        end
                        ACT_COMPUTE: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                            n_drain = 1'b0;
                            n_nm1   = IDX_W'(dim_eff - DIM_W'(1));
                            n_state = (dim_eff == '0) ? ST_DRAIN : ST_CALC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CALC: begin
                // one k step per cycle; k innermost, then j, then i
                o_cmd.mac_issue = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                o_cmd.mac_last  = (r_k == r_nm1);
                if (r_k == r_nm1) begin
                    n_k = '0;
                    if (r_j == r_nm1) begin
                        n_j = '0;
                        if (r_i == r_nm1) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                // wait for the last C write-back, then report completion
                if (r_drain) begin
                    o_cmd.push_done = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    n_drain = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_dim     <= DIM_W'(MAX_DIM);
            r_rd_pend <= 1'b0;
            r_drain   <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_nm1     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_drain   <= n_drain;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_nm1     <= n_nm1;
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
        end
    end

    // A compute item always leaves idle
    a_compute_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_COMPUTE) |=> (r_state != ST_IDLE))
        else $error("compute accepted but controller stayed idle");

    // Loop counters stay inside the region during the walk
    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_i <= r_nm1 && r_j <= r_nm1 && r_k <= r_nm1))
        else $error("loop counter beyond dimension");

    // A read response is never queued in the same cycle as a done result
    a_single_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.push_rd && o_cmd.push_done))
        else $error("two results queued in one cycle");

endmodule

// ----- hw/rtl/tmma_dp.sv -----
// Datapath of the matrix multiply-accumulate block: A, B, C memories, the
// multiply-accumulate pipeline and the result queue. Depends on tmma_pkg.
module tmma_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmma_pkg::t_dp_cmd             i_cmd,
    input  logic [tmma_pkg::IDX_W-1:0]    i_row,
    input  logic [tmma_pkg::IDX_W-1:0]    i_col,
    input  logic [tmma_pkg::DATA_W-1:0]   i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output tmma_pkg::t_out_item           o_out_item,
    output tmma_pkg::t_dp_status          o_status
);
    import tmma_pkg::*;

    logic [DATA_W-1:0] mem_a [CELLS];
    logic [DATA_W-1:0] mem_b [CELLS];
    logic [DATA_W-1:0] mem_c [CELLS];

    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] r_a_q, r_b_q, r_c_q;

    // Stage 1 (memory data) and stage 2 (product) control
    logic              r_s1_v, r_s1_first, r_s1_last;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s2_v, r_s2_first, r_s2_last;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [DATA_W-1:0] r_s2_c, r_prod, r_acc, acc_sum;

    // Result queue
    t_out_item           r_oq [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                push, pop;
    t_out_item           push_item;

    assign wr_addr = {i_row, i_col};

    // A and B: item write, registered read for the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_value;
        end
        r_a_q <= mem_a[i_cmd.a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_value;
        end
        r_b_q <= mem_b[i_cmd.b_addr];
    end

    // C: item write or write-back of a finished element; one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_c) begin
            mem_c[wr_addr] <= i_value;
        end else if (r_s2_v && r_s2_last) begin
            mem_c[r_s2_addr] <= acc_sum;
        end
        r_c_q <= mem_c[i_cmd.c_raddr];
    end

    // Accumulate: start from stored C on the first k, wraps at 32 bits
    assign acc_sum = (r_s2_first ? r_s2_c : r_acc) + r_prod;

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_issue || i_cmd.rd_c) begin
            r_s1_addr <= i_cmd.c_raddr;
        end
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_prod     <= r_a_q * r_b_q;
        r_s2_c     <= r_c_q;
        r_s2_addr  <= r_s1_addr;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s2_v) begin
            r_acc <= acc_sum;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.mac_issue;
            r_s2_v <= r_s1_v;
        end
    end

    // Result to queue: read response or compute-finished marker
    always_comb begin
        push_item = '0;
        if (i_cmd.push_done) begin
            push_item.kind = KIND_DONE;
        end else begin
            push_item.kind  = KIND_READ;
            push_item.row   = r_s1_addr[ADDR_W-1:IDX_W];
            push_item.col   = r_s1_addr[IDX_W-1:0];
            push_item.value = r_c_q;
        end
    end

    assign push        = i_cmd.push_rd || i_cmd.push_done;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_oq[r_rptr];
    assign o_status.oq_count = r_cnt;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_oq[r_wptr] <= push_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < OQ_CNT_W'(OQ_DEPTH) || pop))
        else $error("result queue overflow");

    a_no_c_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_c && r_s2_v && r_s2_last))
        else $error("item write of C during compute write-back");

    a_read_resp_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_c |=> i_cmd.push_rd)
        else $error("read response not queued one cycle after the read");

endmodule
